@@ design/real_input_fft_core_assert.svh @@
// Assertion macros for the real-input FFT files; rif_ctrl includes them.
`ifndef REAL_INPUT_FFT_CORE_ASSERT_SVH
`define REAL_INPUT_FFT_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RIF_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Implication checked in the following cycle.
`define RIF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

@@ design/rif_pkg.sv @@
// ----------------------------------------------------------------------------
// rif_pkg
// Types, constants and the twiddle table of the real-input FFT.
// ----------------------------------------------------------------------------
package rif_pkg;
    localparam int DW = 23;
    localparam int SW = 16;
    localparam logic signed [DW-1:0] SAT_HI = 23'sh3FFFFF;
    localparam logic signed [DW-1:0] SAT_LO = -23'sh400000;

    // Datapath operations.
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_BFLY  = 3'd2;
    localparam logic [2:0] OP_SPLIT = 3'd3;
    localparam logic [2:0] OP_EMIT  = 3'd4;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic [2:0] op;
        logic [5:0] addr_a;
        logic [5:0] addr_b;
        logic [5:0] phase;
        logic       lo_valid;
        logic       hi_valid;
        logic [5:0] bin;
        logic       last;
        logic       first;
    } t_cmd;

    // Quarter-wave sine, Q1.15 with 1.0 as 32768.
    function automatic logic signed [16:0] qsin(input logic [4:0] p);
        logic signed [16:0] v;
        unique case (p)
            5'd0: v = 17'sd0;      5'd1: v = 17'sd3212;   5'd2: v = 17'sd6393;
            5'd3: v = 17'sd9512;   5'd4: v = 17'sd12540;  5'd5: v = 17'sd15447;
            5'd6: v = 17'sd18205;  5'd7: v = 17'sd20788;  5'd8: v = 17'sd23170;
            5'd9: v = 17'sd25330;  5'd10: v = 17'sd27246; 5'd11: v = 17'sd28899;
            5'd12: v = 17'sd30274; 5'd13: v = 17'sd31357; 5'd14: v = 17'sd32138;
            5'd15: v = 17'sd32610; 5'd16: v = 17'sd32768;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    // Full-wave sine at phase 2*pi*p/64.
    function automatic logic signed [16:0] sin64(input logic [5:0] p);
        logic signed [16:0] v;
        if (p <= 6'd16) v = qsin(p[4:0]);
        else if (p <= 6'd32) v = qsin(5'(6'd32 - p));
        else if (p <= 6'd48) v = -qsin(5'(p - 6'd32));
        else v = -qsin(5'(7'd64 - {1'b0, p}));
        return v;
    endfunction

    function automatic logic signed [16:0] cos64(input logic [5:0] p);
        return sin64(6'(p + 6'd16));
    endfunction

    // Saturate a 26-bit value into 23 bits.
    function automatic logic signed [DW-1:0] sat26(input logic signed [25:0] v);
        logic signed [DW-1:0] r;
        if (v > 26'(SAT_HI)) r = SAT_HI;
        else if (v < 26'(SAT_LO)) r = SAT_LO;
        else r = v[DW-1:0];
        return r;
    endfunction
endpackage

@@ design/real_input_fft_core.sv @@
// ----------------------------------------------------------------------------
// real_input_fft_core
// Real-input FFT via a half-length complex FFT and a split step.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle until the programmed count (register value
// plus one, at most N_POINTS) have arrived; the input is then closed while
// N/2 load steps fill the work memory and a shared butterfly unit walks
// log2(N/2) passes of N/4 butterflies, one butterfly per cycle with a wait
// after each pass that covers the pipeline depth, followed by N/2 split
// steps and N bins delivered one at a time, each held back while the output
// register is full and not being read. The phases run in strict serial
// order, so no new samples are taken until the frame's last bin has been
// issued. Configuration is written at any time through i_cfg_we.
module real_input_fft_core
    import rif_pkg::*;
#(
    parameter int N_POINTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [5:0]           i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [15:0]   i_sample,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [5:0]           o_bin_index,
    output logic signed [22:0]   o_real_out,
    output logic signed [22:0]   o_imag_out,
    output logic                 o_last_bin
);
    logic [5:0] r_frame_ord;
    logic       wr;
    logic [5:0] wa;
    t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_frame_ord <= 6'd63;
        else if (i_cfg_we) r_frame_ord <= i_cfg_wdata;
    end

    rif_ctrl #(.N(N_POINTS)) u_ctrl (
        .i_clk, .i_rst_n, .i_frame_ord(r_frame_ord), .i_in_valid(i_valid),
        .o_in_ready(o_ready), .o_wr_sample(wr), .o_wr_addr(wa),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .o_cmd(cmd)
    );

    rif_datapath u_dp (
        .i_clk, .i_rst_n, .i_wr_sample(wr), .i_wr_addr(wa), .i_sample,
        .i_cmd(cmd), .i_out_ready(i_ready), .o_out_valid(o_valid),
        .o_bin_index, .o_real_out, .o_imag_out, .o_last_bin
    );
endmodule

@@ design/rif_datapath.sv @@
// ----------------------------------------------------------------------------
// rif_datapath
// Sample store, work memories, butterfly and split arithmetic, output register.
// ----------------------------------------------------------------------------
module rif_datapath
    import rif_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_sample,
    input  logic [5:0]            i_wr_addr,
    input  logic signed [SW-1:0]  i_sample,
    input  t_cmd                  i_cmd,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [5:0]            o_bin_index,
    output logic signed [DW-1:0]  o_real_out,
    output logic signed [DW-1:0]  o_imag_out,
    output logic                  o_last_bin
);
    logic signed [SW-1:0] r_smp [64];
    logic signed [DW-1:0] r_wre [64];
    logic signed [DW-1:0] r_wim [64];
    logic signed [DW-1:0] r_bre [64];
    logic signed [DW-1:0] r_bim [64];

    // Stage 1: registered memory reads.
    t_cmd r_c1;
    logic signed [SW-1:0] r_sa, r_sb;
    logic signed [DW-1:0] r_ar, r_ai, r_br, r_bi, r_er, r_ei;
    logic signed [16:0] r_cs, r_sn;

    // The even sample sits at addr_a and its odd partner right after it.
    always_ff @(posedge i_clk) begin
        if (i_wr_sample) r_smp[i_wr_addr] <= i_sample;
        r_sa <= r_smp[i_cmd.addr_a];
        r_sb <= r_smp[{i_cmd.addr_a[5:1], 1'b1}];
        r_ar <= r_wre[i_cmd.addr_a];
        r_ai <= r_wim[i_cmd.addr_a];
        r_br <= r_wre[i_cmd.addr_b];
        r_bi <= r_wim[i_cmd.addr_b];
        r_er <= r_bre[i_cmd.bin];
        r_ei <= r_bim[i_cmd.bin];
        r_cs <= cos64(i_cmd.phase);
        r_sn <= sin64(i_cmd.phase);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c1 <= '0;
        else r_c1 <= i_cmd;
    end

    // Stage 2: products, one multiplier each, registered.
    t_cmd r_c2;
    logic signed [40:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [DW-1:0] r_ar2, r_ai2, r_br2, r_bi2;
    logic signed [24:0] xt, yt;
    logic signed [DW-1:0] mr, mi;
    assign xt = 25'(r_ar) - 25'(r_br);
    assign yt = 25'(r_ai) + 25'(r_bi);
    // In split mode operand b is the mirror bin.
    assign mr = (r_c1.op == OP_BFLY) ? r_br : r_bi;
    assign mi = (r_c1.op == OP_BFLY) ? r_bi : r_br;

    always_ff @(posedge i_clk) begin
        if (r_c1.op == OP_BFLY) begin
            r_p1 <= 41'(r_br * r_cs);
            r_p2 <= 41'(r_bi * r_sn);
            r_p3 <= 41'(r_bi * r_cs);
            r_p4 <= 41'(r_br * r_sn);
        end else begin
            r_p1 <= 41'(r_cs * yt);
            r_p2 <= 41'(r_sn * xt);
            r_p3 <= 41'(r_sn * yt);
            r_p4 <= 41'(r_cs * xt);
        end
        r_ar2 <= r_ar; r_ai2 <= r_ai; r_br2 <= mr; r_bi2 <= mi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c2 <= '0;
        else r_c2 <= r_c1;
    end

    // Stage 3: sums, rounding and write-back.
    logic signed [42:0] tr_s, ti_s, re_s, im_s;
    logic signed [25:0] tr, ti, rr, rm;
    logic signed [DW-1:0] sr, sm;
    always_comb begin
        tr_s = 43'(r_p1) + 43'(r_p2) + 43'sd16384;
        ti_s = 43'(r_p3) - 43'(r_p4) + 43'sd16384;
        tr = 26'(tr_s >>> 15);
        ti = 26'(ti_s >>> 15);
        re_s = ((43'(r_ar2) + 43'(r_bi2)) <<< 15) + 43'(r_p1) - 43'(r_p2) + 43'sd32768;
        im_s = ((43'(r_ai2) - 43'(r_br2)) <<< 15) - 43'(r_p3) - 43'(r_p4) + 43'sd32768;
        rr = 26'(re_s >>> 16);
        rm = 26'(im_s >>> 16);
        sr = sat26(rr);
        sm = sat26(rm);
    end

    always_ff @(posedge i_clk) begin
        unique case (r_c1.op)
            OP_LOAD: begin
                r_wre[r_c1.addr_b] <= r_c1.lo_valid ? DW'(r_sa) : '0;
                r_wim[r_c1.addr_b] <= r_c1.hi_valid ? DW'(r_sb) : '0;
            end
            default: ;
        endcase
        unique case (r_c2.op)
            OP_BFLY: begin
                r_wre[r_c2.addr_a] <= sat26(26'(r_ar2) + tr);
                r_wim[r_c2.addr_a] <= sat26(26'(r_ai2) + ti);
                r_wre[r_c2.addr_b] <= sat26(26'(r_ar2) - tr);
                r_wim[r_c2.addr_b] <= sat26(26'(r_ai2) - ti);
            end
            OP_SPLIT: begin
                if (r_c2.first) begin
                    r_bre[r_c2.addr_a] <= sat26(26'(r_ar2) + 26'(r_ai2));
                    r_bim[r_c2.addr_a] <= '0;
                    r_bre[r_c2.bin] <= sat26(26'(r_ar2) - 26'(r_ai2));
                    r_bim[r_c2.bin] <= '0;
                end else begin
                    r_bre[r_c2.addr_a] <= sr;
                    r_bim[r_c2.addr_a] <= sm;
                    r_bre[r_c2.bin] <= sr;
                    r_bim[r_c2.bin] <= sat26(-26'(sm));
                end
            end
            default: ;
        endcase
    end

    // Output register, loaded by emit commands; controller holds while full and not being read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_out_valid <= 1'b0;
        else if (r_c1.op == OP_EMIT) o_out_valid <= 1'b1;
        else if (i_out_ready) o_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (r_c1.op == OP_EMIT) begin
            o_bin_index <= r_c1.bin;
            o_real_out  <= r_er;
            o_imag_out  <= r_ei;
            o_last_bin  <= r_c1.last;
        end
    end
endmodule

@@ design/rif_ctrl.sv @@
// ----------------------------------------------------------------------------
// rif_ctrl
// Frame sequencer: collect, load, butterfly passes, split, emit, drain.
// ----------------------------------------------------------------------------
module rif_ctrl
    import rif_pkg::*;
#(
    parameter int N = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [5:0] i_frame_ord,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_wr_sample,
    output logic [5:0] o_wr_addr,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    output t_cmd       o_cmd
);
    localparam int H  = N / 2;
    localparam int LB = $clog2(H);
    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_LOAD    = 3'd1;
    localparam logic [2:0] S_BFLY    = 3'd2;
    localparam logic [2:0] S_SPLIT   = 3'd3;
    localparam logic [2:0] S_EMIT    = 3'd4;
    localparam logic [2:0] S_DRAIN   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [6:0] r_count, n_count;
    logic [6:0] r_len, n_len;
    logic [5:0] r_idx, n_idx;
    logic [2:0] r_stage, n_stage;
    logic [2:0] r_wait, n_wait;
    logic [6:0] len_cfg;
    logic [5:0] rev;
    logic [5:0] hl, ia, ib, kk, grp;
    logic       em_go;

    assign len_cfg = ({1'b0, i_frame_ord} + 7'd1 > 7'(N)) ? 7'(N) : {1'b0, i_frame_ord} + 7'd1;
    assign o_in_ready  = (r_state == S_COLLECT);
    assign o_wr_sample = i_in_valid && o_in_ready && (r_count < 7'd64);
    assign o_wr_addr   = r_count[5:0];

    // Bit reversal over log2(N/2) bits.
    always_comb begin
        rev = '0;
        for (int b = 0; b < LB; b++) rev[LB-1-b] = r_idx[b];
    end

    // Butterfly addressing for the current pass.
    always_comb begin
        hl  = 6'd1 << r_stage;
        kk  = r_idx & (hl - 6'd1);
        grp = (r_idx >> r_stage) << (r_stage + 3'd1);
        ia  = grp + kk;
        ib  = ia + hl;
    end

    // Emit waits until the output register is empty or being read out.
    assign em_go = !i_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state; n_count = r_count; n_len = r_len;
        n_idx = r_idx; n_stage = r_stage; n_wait = r_wait;
        o_cmd = '0;
        unique case (r_state)
            S_COLLECT: begin
                if (i_in_valid) begin
                    n_count = r_count + 7'd1;
                    if (r_count + 7'd1 >= len_cfg) begin
                        n_count = '0; n_len = len_cfg; n_idx = '0; n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                o_cmd.addr_a = 6'(2 * r_idx);
                o_cmd.addr_b = rev;
                o_cmd.lo_valid = 7'(2 * r_idx) < r_len;
                o_cmd.hi_valid = 7'(2 * r_idx + 1) < r_len;
                n_idx = r_idx + 6'd1;
                if (r_idx == 6'(H - 1)) begin
                    n_idx = '0; n_stage = '0; n_wait = '0; n_state = S_BFLY;
                end
            end
            S_BFLY: begin
                // Idle cycles between passes cover the pipeline depth.
                if (r_wait != 3'd0) begin
                    n_wait = r_wait - 3'd1;
                end else begin
                    o_cmd.op = OP_BFLY;
                    o_cmd.addr_a = ia; o_cmd.addr_b = ib;
                    o_cmd.phase = 6'(kk * (6'd32 >> r_stage));
                    n_idx = r_idx + 6'd1;
                    if (r_idx == 6'(H / 2 - 1)) begin
                        n_idx = '0; n_wait = 3'd3;
                        n_stage = r_stage + 3'd1;
                        if (r_stage == 3'(LB - 1)) begin
                            n_state = S_SPLIT;
                        end
                    end
                end
            end
            S_SPLIT: begin
                if (r_wait != 3'd0) begin
                    n_wait = r_wait - 3'd1;
                end else begin
                    o_cmd.op = OP_SPLIT;
                    o_cmd.first = (r_idx == 6'd0);
                    o_cmd.addr_a = r_idx;
                    o_cmd.addr_b = (r_idx == 6'd0) ? 6'd0 : 6'(H - r_idx);
                    o_cmd.bin = (r_idx == 6'd0) ? 6'(H) : 6'(N - r_idx);
                    o_cmd.phase = 6'(r_idx * (64 / N));
                    n_idx = r_idx + 6'd1;
                    if (r_idx == 6'(H - 1)) begin
                        n_idx = '0; n_wait = 3'd3; n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (r_wait != 3'd0) begin
                    n_wait = r_wait - 3'd1;
                end else if (em_go) begin
                    o_cmd.op = OP_EMIT;
                    o_cmd.bin = r_idx;
                    o_cmd.last = (r_idx == 6'(N - 1));
                    n_idx = r_idx + 6'd1;
                    n_wait = 3'd1;
                    if (r_idx == 6'(N - 1)) begin
                        n_idx = '0; n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (r_wait != 3'd0) n_wait = r_wait - 3'd1;
                else n_state = S_COLLECT;
            end
            default: n_state = S_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT; r_count <= '0; r_len <= '0;
            r_idx <= '0; r_stage <= '0; r_wait <= '0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_len <= n_len;
            r_idx <= n_idx; r_stage <= n_stage; r_wait <= n_wait;
        end
    end

`include "real_input_fft_core_assert.svh"
    `RIF_ASSERT_IMP(a_ready_collect, i_clk, i_rst_n, o_in_ready, r_state == S_COLLECT)
    `RIF_ASSERT_IMP(a_no_cmd_collect, i_clk, i_rst_n, r_state == S_COLLECT, o_cmd.op == OP_NONE)
    `RIF_ASSERT_NEXT(a_emit_spacing, i_clk, i_rst_n, o_cmd.op == OP_EMIT, o_cmd.op != OP_EMIT)
endmodule
